[sv/mcg_pkg.sv]
// Package for the month calendar grid core: types, constants and tables.
`default_nettype none
package mcg_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int IDX_W    = 3;
	localparam int YY_W     = 15;
	localparam int MUL_W    = 15;
	localparam int PROD_W   = 2 * MUL_W;

	localparam int COLUMNS      = 7;
	localparam int WEEKEND_COL  = 5;
	localparam int YEAR_OFFSET  = 400;

	// floor(n / 25) = (n * RECIP_25) >> 16 for n < 4681
	localparam logic [MUL_W-1:0] RECIP_25 = MUL_W'(2622);
	localparam int               SHIFT_25 = 16;
	// floor(s / 7) = (s * RECIP_7) >> 17 for s < 43690
	localparam logic [MUL_W-1:0] RECIP_7  = MUL_W'(18725);
	localparam int               SHIFT_7  = 17;

	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_MAR = MONTH_W'(3);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_Y,
		ST_DIV_YY,
		ST_SUM,
		ST_MOD7,
		ST_EMIT
	} state_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] d;
		case (m)
			4'd2:                   d = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			default:                d = 5'd0;
		endcase
		return d;
	endfunction

	// Sunday-based weekday offset of day 1 of each month
	function automatic logic [2:0] month_shift(input logic [MONTH_W-1:0] m);
		logic [2:0] s;
		case (m)
			4'd1, 4'd5:  s = 3'd0;
			4'd8:        s = 3'd1;
			4'd3, 4'd11: s = 3'd2;
			4'd2, 4'd6:  s = 3'd3;
			4'd9, 4'd12: s = 3'd4;
			4'd4, 4'd7:  s = 3'd5;
			4'd10:       s = 3'd6;
			default:     s = 3'd0;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

[sv/month_calendar_grid_core.sv]
// Top level of the month calendar grid core: weekday sequencer and cell emitter.
`default_nettype none
// One request (year, month) yields rows*7 grid cells, Monday first, rows being
// 4 to 6. After acceptance a sequencer steps through ST_DIV_Y, ST_DIV_YY,
// ST_SUM and ST_MOD7, using a single shared 15x15 multiplier in three of them
// (year/100 for the leap test, adjusted year/100 for the day count, day count
// mod 7) and forming the sum in ST_SUM, then emits one cell per cycle while
// the output is taken. The input is not ready until the last cell has been
// loaded into the output register. An invalid month (0, 13..15) is accepted
// and gives no cells.
module month_calendar_grid_core (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire  [mcg_pkg::YEAR_W-1:0]  year_value,
	input  wire  [mcg_pkg::MONTH_W-1:0] month_value,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [mcg_pkg::DAY_W-1:0]   day_number,
	output logic                        in_month,
	output logic                        weekend_flag,
	output logic [mcg_pkg::IDX_W-1:0]   column_index,
	output logic [mcg_pkg::IDX_W-1:0]   row_index,
	output logic                        last_cell
);

	mcg_pkg::state_t state_q, state_d;

	logic [mcg_pkg::YEAR_W-1:0]  year_q;
	logic [mcg_pkg::MONTH_W-1:0] month_q;
	logic [mcg_pkg::YY_W-1:0]    yy_q;
	logic [7:0]                  qy_q;
	logic [7:0]                  qc_q;
	logic [mcg_pkg::YY_W-1:0]    sum_q;
	logic [mcg_pkg::DAY_W-1:0]   dim_q;
	logic [2:0]                  lead_q;
	logic [2:0]                  rows_q;
	logic [mcg_pkg::IDX_W-1:0]   col_q;
	logic [mcg_pkg::IDX_W-1:0]   row_q;
	logic [5:0]                  day_q;

	logic [mcg_pkg::DAY_W-1:0]   day_number_q;
	logic                        in_month_q, weekend_q, last_q, out_valid_q;
	logic [mcg_pkg::IDX_W-1:0]   column_q, row_out_q;

	logic                        in_fire, month_ok, slot_free, emit_fire, cell_last, cell_in;
	logic [mcg_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic [mcg_pkg::PROD_W-1:0]  prod;
	logic [11:0]                 q7;
	logic [mcg_pkg::YY_W-1:0]    rem7_full;
	logic [2:0]                  rem7;
	logic [2:0]                  lead_d;
	logic [5:0]                  span;
	logic                        div100_y, leap;
	logic [12:0]                 qy_x25;
	logic [mcg_pkg::YY_W-1:0]    yy_in;

	assign month_ok  = (month_value >= mcg_pkg::MONTH_JAN) && (month_value <= mcg_pkg::MONTH_DEC);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign cell_last = (row_q == rows_q - 3'd1) && (col_q == mcg_pkg::IDX_W'(mcg_pkg::COLUMNS - 1));
	assign cell_in   = ((row_q != '0) || (col_q >= lead_q)) && (day_q <= {1'b0, dim_q});

	assign yy_in = mcg_pkg::YY_W'({1'b0, year_value} + mcg_pkg::YY_W'(mcg_pkg::YEAR_OFFSET)
		- mcg_pkg::YY_W'(month_value < mcg_pkg::MONTH_MAR));

	// shared multiplier
	assign prod = mul_a * mul_b;

	assign q7        = prod[mcg_pkg::SHIFT_7 +: 12];
	assign rem7_full = sum_q - mcg_pkg::YY_W'({q7, 3'b000} - {3'b000, q7});
	assign rem7      = rem7_full[2:0];
	assign lead_d    = (rem7 == 3'd0) ? 3'd6 : rem7 - 3'd1;
	assign span      = {3'b000, lead_d} + {1'b0, dim_q};

	assign qy_x25   = 13'({qy_q, 4'b0000} + {2'b00, qy_q, 3'b000} + {5'b00000, qy_q});
	assign div100_y = ({1'b0, year_q[mcg_pkg::YEAR_W-1:2]} == qy_x25);
	assign leap     = (year_q[1:0] == 2'b00) && (!div100_y || (qy_q[1:0] == 2'b00));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mcg_pkg::ST_IDLE:   if (in_valid && month_ok) state_d = mcg_pkg::ST_DIV_Y;
			mcg_pkg::ST_DIV_Y:  state_d = mcg_pkg::ST_DIV_YY;
			mcg_pkg::ST_DIV_YY: state_d = mcg_pkg::ST_SUM;
			mcg_pkg::ST_SUM:    state_d = mcg_pkg::ST_MOD7;
			mcg_pkg::ST_MOD7:   state_d = mcg_pkg::ST_EMIT;
			mcg_pkg::ST_EMIT:   if (slot_free && cell_last) state_d = mcg_pkg::ST_IDLE;
			default:            state_d = mcg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		emit_fire = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			mcg_pkg::ST_IDLE:   in_ready = 1'b1;
			mcg_pkg::ST_DIV_Y: begin
				mul_a = mcg_pkg::MUL_W'(year_q[mcg_pkg::YEAR_W-1:2]);
				mul_b = mcg_pkg::RECIP_25;
			end
			mcg_pkg::ST_DIV_YY: begin
				mul_a = mcg_pkg::MUL_W'(yy_q[mcg_pkg::YY_W-1:2]);
				mul_b = mcg_pkg::RECIP_25;
			end
			mcg_pkg::ST_SUM:    ;
			mcg_pkg::ST_MOD7: begin
				mul_a = sum_q;
				mul_b = mcg_pkg::RECIP_7;
			end
			mcg_pkg::ST_EMIT:   emit_fire = slot_free;
			default:            ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mcg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			year_q  <= year_value;
			month_q <= month_value;
			yy_q    <= yy_in;
		end
		if (state_q == mcg_pkg::ST_DIV_Y)
			qy_q <= prod[mcg_pkg::SHIFT_25 +: 8];
		if (state_q == mcg_pkg::ST_DIV_YY) begin
			qc_q <= prod[mcg_pkg::SHIFT_25 +: 8];
			if (month_q == mcg_pkg::MONTH_FEB && leap)
				dim_q <= mcg_pkg::DAY_W'(29);
			else
				dim_q <= mcg_pkg::month_days(month_q);
		end
		if (state_q == mcg_pkg::ST_SUM)
			sum_q <= mcg_pkg::YY_W'(yy_q + {2'b00, yy_q[mcg_pkg::YY_W-1:2]}
				- {7'd0, qc_q} + {9'd0, qc_q[7:2]}
				+ {12'd0, mcg_pkg::month_shift(month_q)} + mcg_pkg::YY_W'(1));
		if (state_q == mcg_pkg::ST_MOD7) begin
			lead_q <= lead_d;
			rows_q <= (span <= 6'd28) ? 3'd4 : ((span <= 6'd35) ? 3'd5 : 3'd6);
			col_q  <= '0;
			row_q  <= '0;
			day_q  <= 6'd1;
		end
		if (emit_fire) begin
			day_number_q <= cell_in ? day_q[mcg_pkg::DAY_W-1:0] : '0;
			in_month_q   <= cell_in;
			weekend_q    <= cell_in && (col_q >= mcg_pkg::IDX_W'(mcg_pkg::WEEKEND_COL));
			column_q     <= col_q;
			row_out_q    <= row_q;
			last_q       <= cell_last;
			if (cell_in)
				day_q <= day_q + 6'd1;
			if (col_q == mcg_pkg::IDX_W'(mcg_pkg::COLUMNS - 1)) begin
				col_q <= '0;
				row_q <= row_q + 3'd1;
			end else begin
				col_q <= col_q + 3'd1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign day_number   = day_number_q;
	assign in_month     = in_month_q;
	assign weekend_flag = weekend_q;
	assign column_index = column_q;
	assign row_index    = row_out_q;
	assign last_cell    = last_q;

endmodule
`default_nettype wire

[tb/month_calendar_grid_core_test.sv]
// Self-checking testbench for the month calendar grid core with a built-in grid predictor.
`timescale 1ns / 1ps
module month_calendar_grid_core_test;

	localparam int WEEK_LEN    = 7;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 60;
	localparam int RAND_MONTHS = 130;
	localparam int DIR_ROWS    = 24;

	typedef struct {
		logic [mcg_pkg::DAY_W-1:0] day;
		logic                      in_m;
		logic                      wkend;
		logic [mcg_pkg::IDX_W-1:0] col;
		logic [mcg_pkg::IDX_W-1:0] row;
		logic                      last;
	} grid_cell_t;

	typedef struct packed {
		logic [mcg_pkg::YEAR_W-1:0]  year;
		logic [mcg_pkg::MONTH_W-1:0] month;
		logic                        typed;
		logic [2:0]                  lead;
		logic [4:0]                  dim;
	} month_row_t;

	// typed rows carry first-day column and month length read off by hand
	localparam month_row_t DIRECTED [DIR_ROWS] = '{
		'{14'd0,     4'd1,  1'b1, 3'd5, 5'd31},
		'{14'd0,     4'd2,  1'b0, 3'd0, 5'd0},
		'{14'd0,     4'd3,  1'b0, 3'd0, 5'd0},
		'{14'd1,     4'd1,  1'b0, 3'd0, 5'd0},
		'{14'd9999,  4'd12, 1'b0, 3'd0, 5'd0},
		'{14'd16383, 4'd12, 1'b0, 3'd0, 5'd0},
		'{14'd16383, 4'd15, 1'b1, 3'd0, 5'd0},
		'{14'd2000,  4'd2,  1'b0, 3'd0, 5'd0},
		'{14'd1900,  4'd2,  1'b0, 3'd0, 5'd0},
		'{14'd2024,  4'd2,  1'b0, 3'd0, 5'd0},
		'{14'd2021,  4'd2,  1'b1, 3'd0, 5'd28},
		'{14'd5,     4'd0,  1'b1, 3'd0, 5'd0},
		'{14'd10922, 4'd13, 1'b1, 3'd0, 5'd0},
		'{14'd5461,  4'd14, 1'b1, 3'd0, 5'd0},
		'{14'd2024,  4'd4,  1'b0, 3'd0, 5'd0},
		'{14'd2024,  4'd5,  1'b0, 3'd0, 5'd0},
		'{14'd2024,  4'd6,  1'b0, 3'd0, 5'd0},
		'{14'd2024,  4'd7,  1'b0, 3'd0, 5'd0},
		'{14'd2024,  4'd8,  1'b0, 3'd0, 5'd0},
		'{14'd2024,  4'd9,  1'b0, 3'd0, 5'd0},
		'{14'd2024,  4'd10, 1'b0, 3'd0, 5'd0},
		'{14'd2024,  4'd11, 1'b0, 3'd0, 5'd0},
		'{14'd10922, 4'd5,  1'b0, 3'd0, 5'd0},
		'{14'd5461,  4'd10, 1'b0, 3'd0, 5'd0}
	};

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [mcg_pkg::YEAR_W-1:0]   year_value;
	logic [mcg_pkg::MONTH_W-1:0]  month_value;
	logic                         out_valid;
	logic                         out_ready;
	logic [mcg_pkg::DAY_W-1:0]    day_number;
	logic                         in_month;
	logic                         weekend_flag;
	logic [mcg_pkg::IDX_W-1:0]    column_index;
	logic [mcg_pkg::IDX_W-1:0]    row_index;
	logic                         last_cell;

	grid_cell_t pending_cells [$];
	int         mismatches;
	bit         steady;

	month_calendar_grid_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.year_value   (year_value),
		.month_value  (month_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.day_number   (day_number),
		.in_month     (in_month),
		.weekend_flag (weekend_flag),
		.column_index (column_index),
		.row_index    (row_index),
		.last_cell    (last_cell)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// first-day column (Monday 0) and length of a month; zero length if month invalid
	function automatic void month_shape(input logic [mcg_pkg::YEAR_W-1:0] y,
			input logic [mcg_pkg::MONTH_W-1:0] m, output int lead, output int dim);
		int yr, yy, sun_dow;
		bit leap;
		int days_tab [13];
		int shift_tab [12];
		days_tab  = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		shift_tab = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
		lead = 0;
		dim  = 0;
		if (m < mcg_pkg::MONTH_JAN || m > mcg_pkg::MONTH_DEC)
			return;
		yr   = int'(y);
		leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
		dim  = (m == mcg_pkg::MONTH_FEB && leap) ? 29 : days_tab[m];
		yy   = yr + 400;
		if (m < mcg_pkg::MONTH_MAR)
			yy = yy - 1;
		sun_dow = (yy + yy / 4 - yy / 100 + yy / 400 + shift_tab[m - 1] + 1) % 7;
		lead    = (sun_dow + 6) % 7;
	endfunction

	function automatic void queue_grid(input int lead, input int dim);
		int cells, day, k;
		grid_cell_t c;
		cells = ((lead + dim + WEEK_LEN - 1) / WEEK_LEN) * WEEK_LEN;
		day   = 1;
		for (k = 0; k < cells; k++) begin
			c.col = mcg_pkg::IDX_W'(k % WEEK_LEN);
			c.row = mcg_pkg::IDX_W'(k / WEEK_LEN);
			if (k >= lead && day <= dim) begin
				c.day   = mcg_pkg::DAY_W'(day);
				c.in_m  = 1'b1;
				c.wkend = (k % WEEK_LEN) >= 5;
				day++;
			end else begin
				c.day   = '0;
				c.in_m  = 1'b0;
				c.wkend = 1'b0;
			end
			c.last = (k + 1 == cells);
			pending_cells = {pending_cells, c};
		end
	endfunction

	task automatic send_month(input logic [mcg_pkg::YEAR_W-1:0] y,
			input logic [mcg_pkg::MONTH_W-1:0] m, input bit typed, input int lead,
			input int dim);
		int gap, ld, dm;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		year_value  <= y;
		month_value <= m;
		do
			@(posedge clk);
		while (!in_ready);
		if (typed) begin
			queue_grid(lead, dim);
		end else begin
			month_shape(y, m, ld, dm);
			queue_grid(ld, dm);
		end
		if ($urandom_range(0, 24) == 0)
			steady = !steady;
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	task automatic take_cell();
		grid_cell_t c;
		if (pending_cells.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected cell, expected none, actual day %0d row %0d col %0d",
				$time, day_number, row_index, column_index);
			return;
		end
		c = pending_cells.pop_front();
		check_field("day_number", c.day, day_number);
		check_field("in_month", c.in_m, in_month);
		check_field("weekend_flag", c.wkend, weekend_flag);
		check_field("column_index", c.col, column_index);
		check_field("row_index", c.row, row_index);
		check_field("last_cell", c.last, last_cell);
	endtask

	initial begin : cell_sink
		int hold, g;
		hold = 0;
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				take_cell();
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				g = gap_len();
				if (g == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					hold = g - 1;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int i, valid_sent, r;
		logic [mcg_pkg::YEAR_W-1:0]  y;
		logic [mcg_pkg::MONTH_W-1:0] m;
		mismatches  = 0;
		steady      = 1'b0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		year_value  <= '0;
		month_value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++)
			send_month(DIRECTED[i].year, DIRECTED[i].month, DIRECTED[i].typed,
				DIRECTED[i].lead, DIRECTED[i].dim);

		valid_sent = 0;
		while (valid_sent < RAND_MONTHS) begin
			r = $urandom_range(0, 9);
			case (r)
				0, 1, 2, 3, 4: y = mcg_pkg::YEAR_W'($urandom_range(1, 9999));
				5, 6:          y = mcg_pkg::YEAR_W'($urandom_range(0, 16383));
				7:             y = mcg_pkg::YEAR_W'(100 * $urandom_range(0, 163));
				8:             y = mcg_pkg::YEAR_W'(4 * $urandom_range(0, 4095));
				default: begin
					case ($urandom_range(0, 4))
						0:       y = '0;
						1:       y = mcg_pkg::YEAR_W'(1);
						2:       y = mcg_pkg::YEAR_W'(9999);
						3:       y = mcg_pkg::YEAR_W'(16382);
						default: y = '1;
					endcase
				end
			endcase
			if ($urandom_range(0, 9) == 0) begin
				m = mcg_pkg::MONTH_W'($urandom_range(13, 16));
			end else begin
				m = mcg_pkg::MONTH_W'($urandom_range(1, 12));
				valid_sent++;
			end
			send_month(y, m, 1'b0, 0, 0);
		end
		in_valid <= 1'b0;

		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
